FILE: src/bzi_pkg.sv
// ----------------------------------------------------------------------------
// bzi_pkg: shared definitions for barycentric z interpolation
// Default coordinate width and the control word that travels down the
// back half of the pipeline next to the data.
// ----------------------------------------------------------------------------
package bzi_pkg;

	localparam int COORD_BITS_DEF = 16;

	// control word per pipeline stage: valid, result sign, zero determinant
	typedef struct packed {
		logic vld;
		logic neg;
		logic degen;
	} bzi_ctl_t;

endpackage

FILE: src/bzi_front.sv
// ----------------------------------------------------------------------------
// bzi_front: edge vectors, products and 2x2 determinants
// Three stages: differences against vertex C, six products, then the
// determinant D and the two Cramer numerators N1 and N2.
// ----------------------------------------------------------------------------
module bzi_front
	import bzi_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_vld,
	input  logic signed [COORD_BITS-1:0]   ax,
	input  logic signed [COORD_BITS-1:0]   ay,
	input  logic signed [COORD_BITS-1:0]   az,
	input  logic signed [COORD_BITS-1:0]   bx,
	input  logic signed [COORD_BITS-1:0]   by_coord,
	input  logic signed [COORD_BITS-1:0]   bz,
	input  logic signed [COORD_BITS-1:0]   cx,
	input  logic signed [COORD_BITS-1:0]   cy,
	input  logic signed [COORD_BITS-1:0]   cz,
	input  logic signed [COORD_BITS-1:0]   px,
	input  logic signed [COORD_BITS-1:0]   py,
	output logic                           out_vld,
	output logic signed [2*COORD_BITS+2:0] d,
	output logic signed [2*COORD_BITS+2:0] n1,
	output logic signed [2*COORD_BITS+2:0] n2,
	output logic signed [COORD_BITS:0]     azc,
	output logic signed [COORD_BITS:0]     bzc,
	output logic signed [COORD_BITS-1:0]   cz_o
);

	localparam int W  = COORD_BITS;
	localparam int PW = 2 * W + 2;
	localparam int CW = 2 * W + 3;

	logic                  vld_s1, vld_s2, vld_s3;
	logic signed [W:0]     acx_s1, acy_s1, bcx_s1, bcy_s1, pcx_s1, pcy_s1;
	logic signed [W:0]     azc_s1, bzc_s1, azc_s2, bzc_s2, azc_s3, bzc_s3;
	logic signed [W-1:0]   cz_s1, cz_s2, cz_s3;
	logic signed [PW-1:0]  pab_s2, pba_s2, ppb_s2, pbp_s2, pap_s2, ppa_s2;
	logic signed [CW-1:0]  d_s3, n1_s3, n2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// edge vectors relative to vertex C
	always_ff @(posedge clk) begin
		acx_s1 <= $signed({ax[W-1], ax}) - $signed({cx[W-1], cx});
		acy_s1 <= $signed({ay[W-1], ay}) - $signed({cy[W-1], cy});
		bcx_s1 <= $signed({bx[W-1], bx}) - $signed({cx[W-1], cx});
		bcy_s1 <= $signed({by_coord[W-1], by_coord}) - $signed({cy[W-1], cy});
		pcx_s1 <= $signed({px[W-1], px}) - $signed({cx[W-1], cx});
		pcy_s1 <= $signed({py[W-1], py}) - $signed({cy[W-1], cy});
		azc_s1 <= $signed({az[W-1], az}) - $signed({cz[W-1], cz});
		bzc_s1 <= $signed({bz[W-1], bz}) - $signed({cz[W-1], cz});
		cz_s1  <= cz;
	end

	// six products of the cross terms
	always_ff @(posedge clk) begin
		pab_s2 <= acx_s1 * bcy_s1;
		pba_s2 <= bcx_s1 * acy_s1;
		ppb_s2 <= pcx_s1 * bcy_s1;
		pbp_s2 <= bcx_s1 * pcy_s1;
		pap_s2 <= acx_s1 * pcy_s1;
		ppa_s2 <= pcx_s1 * acy_s1;
		azc_s2 <= azc_s1;
		bzc_s2 <= bzc_s1;
		cz_s2  <= cz_s1;
	end

	always_ff @(posedge clk) begin
		d_s3   <= pab_s2 - pba_s2;
		n1_s3  <= ppb_s2 - pbp_s2;
		n2_s3  <= pap_s2 - ppa_s2;
		azc_s3 <= azc_s2;
		bzc_s3 <= bzc_s2;
		cz_s3  <= cz_s2;
	end

	assign out_vld = vld_s3;
	assign d       = d_s3;
	assign n1      = n1_s3;
	assign n2      = n2_s3;
	assign azc     = azc_s3;
	assign bzc     = bzc_s3;
	assign cz_o    = cz_s3;

endmodule

FILE: src/bzi_numer.sv
// ----------------------------------------------------------------------------
// bzi_numer: weighted numerator and divider operands
// Split products of N1*(az-cz) and N2*(bz-cz), their sum N, then the
// rounded-division operands 2|N|+|D| and 2|D| with the result sign.
// ----------------------------------------------------------------------------
module bzi_numer
	import bzi_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_vld,
	input  logic signed [2*COORD_BITS+2:0] d,
	input  logic signed [2*COORD_BITS+2:0] n1,
	input  logic signed [2*COORD_BITS+2:0] n2,
	input  logic signed [COORD_BITS:0]     azc,
	input  logic signed [COORD_BITS:0]     bzc,
	input  logic signed [COORD_BITS-1:0]   cz,
	output bzi_ctl_t                       out_ctl,
	output logic [3*COORD_BITS+6:0]        num,
	output logic [2*COORD_BITS+3:0]        div,
	output logic signed [COORD_BITS-1:0]   cz_o
);

	localparam int W    = COORD_BITS;
	localparam int CW   = 2 * W + 3;
	localparam int H    = W + 2;
	localparam int LW   = H + W + 1;
	localparam int HW   = 2 * W + 2;
	localparam int MW   = 3 * W + 4;
	localparam int NW   = 3 * W + 5;
	localparam int NUMW = NW + 2;
	localparam int DVW  = CW + 1;

	logic                 vld_s1, vld_s2, vld_s3;
	logic signed [LW-1:0] p1lo_s1, p2lo_s1;
	logic signed [HW-1:0] p1hi_s1, p2hi_s1;
	logic signed [CW-1:0] d_s1, d_s2, d_s3;
	logic signed [W-1:0]  cz_s1, cz_s2, cz_s3, cz_s4;
	logic signed [MW-1:0] m1_s2, m2_s2;
	logic signed [NW-1:0] n_s3;
	bzi_ctl_t             ctl_s4;
	logic [NUMW-1:0]      num_s4;
	logic [DVW-1:0]       div_s4;
	logic [NW-1:0]        an;
	logic [CW-1:0]        ad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			ctl_s4 <= '0;
		end else begin
			vld_s1     <= in_vld;
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			ctl_s4.vld <= vld_s3;
			ctl_s4.neg <= n_s3[NW-1] ^ d_s3[CW-1];
			ctl_s4.degen <= (d_s3 == '0);
		end
	end

	// cut each wide numerator into an unsigned low part and a signed high part, then multiply each part
	always_ff @(posedge clk) begin
		p1lo_s1 <= $signed({1'b0, n1[H-1:0]}) * azc;
		p1hi_s1 <= $signed(n1[CW-1:H]) * azc;
		p2lo_s1 <= $signed({1'b0, n2[H-1:0]}) * bzc;
		p2hi_s1 <= $signed(n2[CW-1:H]) * bzc;
		d_s1    <= d;
		cz_s1   <= cz;
	end

	always_ff @(posedge clk) begin
		m1_s2 <= $signed({p1hi_s1, {H{1'b0}}}) + p1lo_s1;
		m2_s2 <= $signed({p2hi_s1, {H{1'b0}}}) + p2lo_s1;
		d_s2  <= d_s1;
		cz_s2 <= cz_s1;
	end

	always_ff @(posedge clk) begin
		n_s3  <= m1_s2 + m2_s2;
		d_s3  <= d_s2;
		cz_s3 <= cz_s2;
	end

	always_comb begin
		an = n_s3[NW-1] ? NW'(-n_s3) : NW'(n_s3);
		ad = d_s3[CW-1] ? CW'(-d_s3) : CW'(d_s3);
	end

	// round half away from zero: (2|N| + |D|) / (2|D|)
	always_ff @(posedge clk) begin
		num_s4 <= {an, 1'b0} + NUMW'(ad);
		div_s4 <= {ad, 1'b0};
		cz_s4  <= cz_s3;
	end

	assign out_ctl = ctl_s4;
	assign num     = num_s4;
	assign div     = div_s4;
	assign cz_o    = cz_s4;

endmodule

FILE: src/bzi_div.sv
// ----------------------------------------------------------------------------
// bzi_div: pipelined restoring divider
// One overflow check stage, then one quotient bit per stage. Quotients too
// large for the saturating output only raise the overflow bit.
// ----------------------------------------------------------------------------
module bzi_div
	import bzi_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bzi_ctl_t                     in_ctl,
	input  logic [3*COORD_BITS+6:0]      num,
	input  logic [2*COORD_BITS+3:0]      div,
	input  logic signed [COORD_BITS-1:0] cz,
	output bzi_ctl_t                     out_ctl,
	output logic                         ovf,
	output logic [COORD_BITS+1:0]        quo,
	output logic signed [COORD_BITS-1:0] cz_o
);

	localparam int W    = COORD_BITS;
	localparam int QW   = W + 2;
	localparam int NUMW = 3 * W + 7;
	localparam int DVW  = 2 * W + 4;

	logic [NUMW-QW-1:0]  num_hi;

	bzi_ctl_t            ctl_sk [QW+1];
	logic                ovf_sk [QW+1];
	logic [DVW-1:0]      rem_sk [QW+1];
	logic [DVW-1:0]      div_sk [QW+1];
	logic [QW-1:0]       low_sk [QW+1];
	logic [QW-1:0]       quo_sk [QW+1];
	logic signed [W-1:0] cz_sk  [QW+1];

	assign num_hi = num[NUMW-1:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sk[0] <= '0;
		end else begin
			ctl_sk[0] <= in_ctl;
		end
	end

	// quotient fits QW bits exactly when the top part stays below the divisor
	always_ff @(posedge clk) begin
		ovf_sk[0] <= (num_hi >= {1'b0, div});
		rem_sk[0] <= num_hi[DVW-1:0];
		div_sk[0] <= div;
		low_sk[0] <= num[QW-1:0];
		quo_sk[0] <= '0;
		cz_sk[0]  <= cz;
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DVW:0] trial;
		logic         take;

		always_comb begin
			trial = {rem_sk[k], low_sk[k][QW-1]};
			take  = (trial >= {1'b0, div_sk[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_sk[k+1] <= '0;
			end else begin
				ctl_sk[k+1] <= ctl_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_sk[k+1] <= take ? DVW'(trial - {1'b0, div_sk[k]}) : trial[DVW-1:0];
			quo_sk[k+1] <= {quo_sk[k][QW-2:0], take};
			low_sk[k+1] <= {low_sk[k][QW-2:0], 1'b0};
			div_sk[k+1] <= div_sk[k];
			ovf_sk[k+1] <= ovf_sk[k];
			cz_sk[k+1]  <= cz_sk[k];
		end
	end

	assign out_ctl = ctl_sk[QW];
	assign ovf     = ovf_sk[QW];
	assign quo     = quo_sk[QW];
	assign cz_o    = cz_sk[QW];

endmodule

FILE: src/barycentric_z_interpolation_top.sv
// ----------------------------------------------------------------------------
// barycentric_z_interpolation_top: plane interpolation of z over a triangle
// Fully pipelined, one item per clock, one result per item.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: drive the eleven coordinates and raise start. An item is
//   taken at every rising edge with start high and busy low. busy is held
//   low: the pipeline never stalls, so an item may enter every cycle.
//   Output channel: done is high for exactly one cycle per item, with z_out
//   and degenerate valid in that cycle. The receiver must take it then.
// Pipeline stages and throughput
//   From acceptance to done an item passes 3 stages of edge vectors,
//   products and determinants, 4 stages of split weighted products, sum and
//   operand forming, 1 overflow check stage, COORD_BITS + 2 restoring divider
//   stages (one quotient bit each), and 1 output stage. One item per cycle
//   sustained; results keep input order.
// Arithmetic
//   z_out = cz + round(N / D), ties away from zero, saturated to COORD_BITS.
//   D == 0 raises degenerate and returns cz.
// Reset
//   arst_n clears every valid bit at once; items in flight are dropped and
//   no done pulse follows until a new item is accepted.
// ----------------------------------------------------------------------------
module barycentric_z_interpolation_top
	import bzi_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] ay,
	input  logic signed [COORD_BITS-1:0] az,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] by_coord,
	input  logic signed [COORD_BITS-1:0] bz,
	input  logic signed [COORD_BITS-1:0] cx,
	input  logic signed [COORD_BITS-1:0] cy,
	input  logic signed [COORD_BITS-1:0] cz,
	input  logic signed [COORD_BITS-1:0] px,
	input  logic signed [COORD_BITS-1:0] py,
	output logic                         done,
	output logic signed [COORD_BITS-1:0] z_out,
	output logic                         degenerate
);

	localparam int W   = COORD_BITS;
	localparam int CW  = 2 * W + 3;
	localparam int QW  = W + 2;
	localparam int TW  = QW + 2;
	localparam logic signed [TW-1:0] ZMAX = $signed({{(TW-W+1){1'b0}}, {(W-1){1'b1}}});
	localparam logic signed [TW-1:0] ZMIN = $signed({{(TW-W+1){1'b1}}, {(W-1){1'b0}}});

	logic                  fr_vld;
	logic signed [CW-1:0]  fr_d, fr_n1, fr_n2;
	logic signed [W:0]     fr_azc, fr_bzc;
	logic signed [W-1:0]   fr_cz;

	bzi_ctl_t              nm_ctl;
	logic [3*W+6:0]        nm_num;
	logic [2*W+3:0]        nm_div;
	logic signed [W-1:0]   nm_cz;

	bzi_ctl_t              dv_ctl;
	logic                  dv_ovf;
	logic [QW-1:0]         dv_quo;
	logic signed [W-1:0]   dv_cz;

	logic signed [QW:0]    qs;
	logic signed [TW-1:0]  t;
	logic signed [W-1:0]   z_next;

	logic                  done_s1;
	logic signed [W-1:0]   z_s1;
	logic                  degen_s1;

	// the pipeline never holds off an item
	assign busy = 1'b0;

	bzi_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start && !busy),
		.ax       (ax),
		.ay       (ay),
		.az       (az),
		.bx       (bx),
		.by_coord (by_coord),
		.bz       (bz),
		.cx       (cx),
		.cy       (cy),
		.cz       (cz),
		.px       (px),
		.py       (py),
		.out_vld  (fr_vld),
		.d        (fr_d),
		.n1       (fr_n1),
		.n2       (fr_n2),
		.azc      (fr_azc),
		.bzc      (fr_bzc),
		.cz_o     (fr_cz)
	);

	bzi_numer #(
		.COORD_BITS(COORD_BITS)
	) u_numer (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (fr_vld),
		.d       (fr_d),
		.n1      (fr_n1),
		.n2      (fr_n2),
		.azc     (fr_azc),
		.bzc     (fr_bzc),
		.cz      (fr_cz),
		.out_ctl (nm_ctl),
		.num     (nm_num),
		.div     (nm_div),
		.cz_o    (nm_cz)
	);

	bzi_div #(
		.COORD_BITS(COORD_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (nm_ctl),
		.num     (nm_num),
		.div     (nm_div),
		.cz      (nm_cz),
		.out_ctl (dv_ctl),
		.ovf     (dv_ovf),
		.quo     (dv_quo),
		.cz_o    (dv_cz)
	);

	// apply the sign, add cz, then clamp; overflow saturates toward the sign, degenerate returns cz
	always_comb begin
		qs = $signed({1'b0, dv_quo});
		t  = dv_ctl.neg ? (TW'(dv_cz) - TW'(qs)) : (TW'(dv_cz) + TW'(qs));
		if (dv_ctl.degen) begin
			z_next = dv_cz;
		end else if (dv_ovf) begin
			z_next = dv_ctl.neg ? ZMIN[W-1:0] : ZMAX[W-1:0];
		end else if (t > ZMAX) begin
			z_next = ZMAX[W-1:0];
		end else if (t < ZMIN) begin
			z_next = ZMIN[W-1:0];
		end else begin
			z_next = t[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= dv_ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		z_s1     <= z_next;
		degen_s1 <= dv_ctl.degen;
	end

	assign done       = done_s1;
	assign z_out      = z_s1;
	assign degenerate = degen_s1;

endmodule

FILE: src/bzi_checker.sv
// ----------------------------------------------------------------------------
// bzi_port_checker: port-level checks for barycentric z interpolation
// Fixed latency in both directions, degenerate result and flat-plane result.
// ----------------------------------------------------------------------------
module bzi_port_checker
	import bzi_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic signed [COORD_BITS-1:0] az,
	input logic signed [COORD_BITS-1:0] bz,
	input logic signed [COORD_BITS-1:0] cz,
	input logic                         done,
	input logic signed [COORD_BITS-1:0] z_out,
	input logic                         degenerate
);

	localparam int LAT = COORD_BITS + 11;

	a_done_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("done without an item accepted LAT cycles earlier");

	a_item_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted item produced no result at fixed latency");

	a_degen_returns_cz: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (z_out == $past(cz, LAT)))
		else $error("degenerate result is not the third vertex z");

	a_flat_plane: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !degenerate && $past(az == cz && bz == cz, LAT))
			|-> (z_out == $past(cz, LAT)))
		else $error("flat triangle did not return its common z");

endmodule

bind barycentric_z_interpolation_top bzi_port_checker #(
	.COORD_BITS(COORD_BITS)
) u_bzi_checker (.*);
